>>> design/assert_macros.svh
// Assertion macros shared by the route table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);
`define ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define ASSERT_ALWAYS(label, cond, msg)
`define ASSERT_IMPLY(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

>>> design/lpm_pkg.sv
// Types, constants and helper functions of the longest prefix match route table.
package lpm_pkg;

   localparam int MAX_ROUTES = 64;
   localparam int IDX_W      = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
   localparam int COUNT_W    = $clog2(MAX_ROUTES + 1);
   localparam int PLEN_W     = 6;

   localparam logic FUNC_ADD    = 1'b0;
   localparam logic FUNC_LOOKUP = 1'b1;

   typedef enum logic [1:0] {
      STATUS_ADDED = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_HIT   = 2'd2,
      STATUS_MISS  = 2'd3
   } status_type;

   typedef struct packed {
      logic        func;
      logic [31:0] route_network;
      logic [31:0] route_mask;
      logic [31:0] route_next_hop;
      logic [7:0]  route_port;
      logic [31:0] lookup_address;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [31:0]       best_next_hop;
      logic [7:0]        best_port;
      logic [PLEN_W-1:0] best_prefix_length;
   } rsp_type;

   typedef struct packed {
      logic [31:0]       network;
      logic [31:0]       mask;
      logic [31:0]       next_hop;
      logic [7:0]        port;
      logic [PLEN_W-1:0] prefix_length;
   } entry_type;

   typedef struct packed {
      logic latch_req;
      logic do_add;
      logic scan_rd;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_lookup;
      logic table_empty;
      logic scan_last;
   } ctrl_status_type;

   // adder tree popcount of a 32-bit mask
   function automatic logic [PLEN_W-1:0] count_ones(input logic [31:0] v);
      logic [1:0] s1 [16];
      logic [2:0] s2 [8];
      logic [3:0] s3 [4];
      logic [4:0] s4 [2];
      for (int i = 0; i < 16; i++) begin
         s1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
      end
      for (int i = 0; i < 8; i++) begin
         s2[i] = {1'b0, s1[2*i]} + {1'b0, s1[2*i+1]};
      end
      for (int i = 0; i < 4; i++) begin
         s3[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
      end
      for (int i = 0; i < 2; i++) begin
         s4[i] = {1'b0, s3[2*i]} + {1'b0, s3[2*i+1]};
      end
      return {1'b0, s4[0]} + {1'b0, s4[1]};
   endfunction

endpackage

>>> design/lpm_datapath.sv
// Route table datapath: request register, entry memory, scan counter and best-match tracking.
`include "assert_macros.svh"
module lpm_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  lpm_pkg::req_type         req_data,
   input  lpm_pkg::ctrl_cmd_type    cmd,
   output lpm_pkg::ctrl_status_type status,
   output lpm_pkg::rsp_type         rsp_data
);
   import lpm_pkg::*;

   req_type            req_ff;
   entry_type          mem [MAX_ROUTES];
   entry_type          rd_data_ff;
   entry_type          new_entry;
   logic               rd_valid_ff;
   logic [COUNT_W-1:0] entry_count_ff;
   logic [COUNT_W-1:0] entry_count_in;
   logic [IDX_W-1:0]   scan_idx_ff;
   logic [IDX_W-1:0]   scan_idx_in;
   logic               found_ff;
   logic               found_in;
   logic               add_ok_ff;
   logic               add_ok_in;
   logic [31:0]        best_hop_ff;
   logic [7:0]         best_port_ff;
   logic [PLEN_W-1:0]  best_plen_ff;
   logic               full;
   logic               entry_hit;
   logic               take;

   assign full = (entry_count_ff == COUNT_W'(MAX_ROUTES));

   assign new_entry.network       = req_ff.route_network;
   assign new_entry.mask          = req_ff.route_mask;
   assign new_entry.next_hop      = req_ff.route_next_hop;
   assign new_entry.port          = req_ff.route_port;
   assign new_entry.prefix_length = count_ones(req_ff.route_mask);

   // entry read last cycle is compared against the address now
   assign entry_hit = (((req_ff.lookup_address ^ rd_data_ff.network) & rd_data_ff.mask) == 32'd0);
   assign take      = rd_valid_ff && entry_hit &&
                      (!found_ff || (rd_data_ff.prefix_length > best_plen_ff));

   always_comb begin
      entry_count_in = entry_count_ff;
      add_ok_in      = add_ok_ff;
      found_in       = found_ff;
      scan_idx_in    = scan_idx_ff;
      if (cmd.latch_req) begin
         found_in    = 1'b0;
         add_ok_in   = 1'b0;
         scan_idx_in = '0;
      end else begin
         if (cmd.do_add) begin
            add_ok_in = !full;
            if (!full) begin
               entry_count_in = entry_count_ff + COUNT_W'(1);
            end
         end
         if (cmd.scan_rd) begin
            scan_idx_in = scan_idx_ff + IDX_W'(1);
         end
         if (take) begin
            found_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
         rd_valid_ff    <= 1'b0;
         found_ff       <= 1'b0;
         add_ok_ff      <= 1'b0;
         scan_idx_ff    <= '0;
      end else begin
         entry_count_ff <= entry_count_in;
         rd_valid_ff    <= cmd.scan_rd;
         found_ff       <= found_in;
         add_ok_ff      <= add_ok_in;
         scan_idx_ff    <= scan_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         req_ff <= req_data;
      end
      if (cmd.latch_req) begin
         best_hop_ff  <= '0;
         best_port_ff <= '0;
         best_plen_ff <= '0;
      end else if (take) begin
         best_hop_ff  <= rd_data_ff.next_hop;
         best_port_ff <= rd_data_ff.port;
         best_plen_ff <= rd_data_ff.prefix_length;
      end
   end

   // entry memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.do_add && !full) begin
         mem[entry_count_ff[IDX_W-1:0]] <= new_entry;
      end
      if (cmd.scan_rd) begin
         rd_data_ff <= mem[scan_idx_ff];
      end
   end

   assign status.is_lookup   = (req_ff.func == FUNC_LOOKUP);
   assign status.table_empty = (entry_count_ff == '0);
   assign status.scan_last   = ((COUNT_W'(scan_idx_ff) + COUNT_W'(1)) == entry_count_ff);

   always_comb begin
      if (req_ff.func == FUNC_ADD) begin
         rsp_data.status = add_ok_ff ? STATUS_ADDED : STATUS_FULL;
      end else begin
         rsp_data.status = found_ff ? STATUS_HIT : STATUS_MISS;
      end
      rsp_data.best_next_hop      = best_hop_ff;
      rsp_data.best_port          = best_port_ff;
      rsp_data.best_prefix_length = best_plen_ff;
   end

   `ASSERT_ALWAYS(a_count_bound, entry_count_ff <= COUNT_W'(MAX_ROUTES), "entry count past table size")
   `ASSERT_NEXT(a_full_holds, cmd.do_add && full, $stable(entry_count_ff), "add into full table changed count")
   `ASSERT_NEXT(a_best_cleared, cmd.latch_req, !found_ff && (best_plen_ff == '0), "best match not cleared on new request")

endmodule

>>> design/lpm_ctrl.sv
// Route table controller: sequences add, scan and response for each transfer.
`include "assert_macros.svh"
module lpm_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   output logic                    rsp_strobe,
   input  lpm_pkg::ctrl_status_type status,
   output lpm_pkg::ctrl_cmd_type    cmd
);
   import lpm_pkg::*;

   typedef enum logic [4:0] {
      IDLE   = 5'b00001,
      DECODE = 5'b00010,
      SCAN   = 5'b00100,
      DRAIN  = 5'b01000,
      RESP   = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         IDLE: begin
            if (start) begin
               cmd.latch_req = 1'b1;
               state_in      = DECODE;
            end
         end
         DECODE: begin
            if (!status.is_lookup) begin
               cmd.do_add = 1'b1;
               state_in   = RESP;
            end else if (status.table_empty) begin
               state_in = RESP;
            end else begin
               state_in = SCAN;
            end
         end
         SCAN: begin
            cmd.scan_rd = 1'b1;
            if (status.scan_last) begin
               state_in = DRAIN;
            end
         end
         // last entry read is compared in this cycle
         DRAIN: begin
            state_in = RESP;
         end
         RESP: begin
            state_in = IDLE;
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy       = (state_ff != IDLE);
   assign rsp_strobe = (state_ff == RESP);

   `ASSERT_NEXT(a_accept_decode, start && (state_ff == IDLE), state_ff == DECODE, "accepted transfer not decoded")
   `ASSERT_NEXT(a_scan_end, (state_ff == SCAN) && status.scan_last, state_ff == DRAIN, "scan overran last entry")
   `ASSERT_NEXT(a_resp_single, state_ff == RESP, state_ff == IDLE, "response held beyond one cycle")

endmodule

>>> design/longest_prefix_match_table_unit.sv
// Top level of the longest prefix match route table.
// Usage:
//   Input: drive req_data and raise start; the transfer is taken at a rising edge with
//   start high and busy low. req_data.func selects an add (0) or a lookup (1).
//   Output: one result per transfer on rsp_data, marked by rsp_strobe for a single
//   cycle; the receiver must take it then, as there is no way to hold it off.
//   Sequence: an add passes from decode straight to the response; a lookup passes
//   through decode, a scan of the N stored entries, a drain state and the response,
//   skipping the scan on an empty table. A new transfer is taken only after the
//   response of the last one. The scan reads one entry a cycle from the entry memory
//   and compares it against the address in the following cycle.
//   Adds append at the fill count; once MAX_ROUTES entries are held, adds are
//   dropped and answered with the table-full status.
//   Reset: synchronous, active high; empties the table (fill count to zero) and
//   returns to idle. The entry memory itself is not cleared.
module longest_prefix_match_table_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  lpm_pkg::req_type req_data,
   output logic             rsp_strobe,
   output lpm_pkg::rsp_type rsp_data
);
   import lpm_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   lpm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .status     (status),
      .cmd        (cmd)
   );

   lpm_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule
